/* rtl/pfs_pkg.sv */
// pfs_pkg: shared constants, widths and the command/status bundles of the
// prime factor statistics block. Used by every module under rtl/ but pfs_checker.
package pfs_pkg;

  // operand width actually factored; the value port keeps its fixed width
  localparam int VALUE_BITS = 20;

  localparam int W_VALUE    = 20;
  localparam int W_PRIME    = 20;
  localparam int W_DISTINCT = 4;
  localparam int W_TOTAL    = 5;
  localparam int W_DCOUNT   = 8;
  localparam int W_DSUM     = 23;

  // candidate divisor must reach just past sqrt(2^VALUE_BITS)
  localparam int D_BITS    = VALUE_BITS / 2 + 2;
  localparam int SQ_BITS   = 2 * D_BITS;
  localparam int E_BITS    = $clog2(VALUE_BITS + 2);
  // radix-4 divider: two quotient bits per cycle
  localparam int DIV_STEPS = (VALUE_BITS + 1) / 2;
  localparam int DIV_W     = 2 * DIV_STEPS;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic load;
    logic div_start;
    logic take;
    logic merge;
    logic advance;
    logic tail;
  } pfs_cmd_t;

  typedef struct packed {
    logic sq_over;
    logic div_done;
    logic div_zero;
    logic hit;
  } pfs_stat_t;

endpackage

/* rtl/pfs_div.sv */
// pfs_div: multi-cycle unsigned divider, two restoring steps per cycle.
// Depends on pfs_pkg for operand widths.
module pfs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pfs_pkg::VALUE_BITS-1:0] dividend,
  input  logic [pfs_pkg::D_BITS-1:0]     divisor,
  output logic                           done,
  output logic [pfs_pkg::VALUE_BITS-1:0] quotient,
  output logic                           rem_zero
);
  import pfs_pkg::*;

  logic              run;
  logic [DIV_CW-1:0] cnt;
  logic [D_BITS-1:0] rem, rem_next;
  logic [DIV_W-1:0]  sh, sh_next;

  always_comb begin
    logic [D_BITS:0]   t;
    logic [D_BITS-1:0] r;
    logic [DIV_W-1:0]  s;
    r = rem;
    s = sh;
    for (int k = 0; k < 2; k++) begin
      t = {r, s[DIV_W-1]};
      s = {s[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        s[0] = 1'b1;
      end
      r = t[D_BITS-1:0];
    end
    rem_next = r;
    sh_next  = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CW'(DIV_STEPS);
      end else if (run) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= DIV_W'(dividend);
      rem <= '0;
    end else if (run) begin
      sh  <= sh_next;
      rem <= rem_next;
    end
  end

  assign quotient = sh[VALUE_BITS-1:0];
  assign rem_zero = (rem == '0);

endmodule

/* rtl/pfs_datapath.sv */
// pfs_datapath: remainder, candidate divisor and factor statistics registers.
// Depends on pfs_pkg and instantiates pfs_div.
module pfs_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pfs_pkg::W_VALUE-1:0]    value,
  input  pfs_pkg::pfs_cmd_t              cmd,
  output pfs_pkg::pfs_stat_t             stat,
  output logic [pfs_pkg::W_PRIME-1:0]    smallest_prime,
  output logic [pfs_pkg::W_PRIME-1:0]    largest_prime,
  output logic [pfs_pkg::W_DISTINCT-1:0] distinct_primes,
  output logic [pfs_pkg::W_TOTAL-1:0]    total_primes,
  output logic [pfs_pkg::W_DCOUNT-1:0]   divisor_count,
  output logic [pfs_pkg::W_DSUM-1:0]     divisor_sum
);
  import pfs_pkg::*;

  logic [VALUE_BITS-1:0] n, rest, least, most, quotient;
  logic [D_BITS-1:0]     d;
  logic [SQ_BITS-1:0]    sq;
  logic [W_DISTINCT-1:0] distinct;
  logic [W_TOTAL-1:0]    total;
  logic [W_DCOUNT-1:0]   dcount, dcount_prod;
  logic [W_DSUM-1:0]     dsum, series, series_next, dsum_op, dsum_prod;
  logic [E_BITS-1:0]     e;
  logic                  hit, below_two, div_done, rem_zero;

  pfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rest),
    .divisor  (d),
    .done     (div_done),
    .quotient (quotient),
    .rem_zero (rem_zero)
  );

  assign n  = VALUE_BITS'(value);
  assign sq = SQ_BITS'(d) * SQ_BITS'(d);

  // running 1 + d + ... + d^e, kept modulo the output width
  assign series_next = series * W_DSUM'(d) + W_DSUM'(1);
  // one multiplier serves the per-prime merge and the leftover prime
  assign dsum_op     = cmd.tail ? (W_DSUM'(rest) + W_DSUM'(1)) : series;
  assign dsum_prod   = dsum * dsum_op;
  assign dcount_prod = dcount * (W_DCOUNT'(e) + W_DCOUNT'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      below_two <= (n < VALUE_BITS'(2));
      rest      <= n;
      d         <= D_BITS'(2);
      least     <= '0;
      most      <= '0;
      distinct  <= '0;
      total     <= '0;
      dcount    <= W_DCOUNT'(1);
      dsum      <= W_DSUM'(1);
      series    <= W_DSUM'(1);
      e         <= '0;
      hit       <= 1'b0;
    end else begin
      if (cmd.take) begin
        rest   <= quotient;
        e      <= e + E_BITS'(1);
        series <= series_next;
        if (!hit) begin
          hit      <= 1'b1;
          distinct <= distinct + W_DISTINCT'(1);
          most     <= VALUE_BITS'(d);
          if (least == '0) begin
            least <= VALUE_BITS'(d);
          end
        end
      end
      if (cmd.merge) begin
        dsum   <= dsum_prod;
        dcount <= dcount_prod;
        total  <= total + W_TOTAL'(e);
        e      <= '0;
        series <= W_DSUM'(1);
        hit    <= 1'b0;
      end
      if (cmd.advance) begin
        // 2, then odd candidates only
        d <= (d == D_BITS'(2)) ? D_BITS'(3) : d + D_BITS'(2);
      end
      if (cmd.tail && (rest > VALUE_BITS'(1))) begin
        if (least == '0) begin
          least <= rest;
        end
        if (rest > most) begin
          most <= rest;
        end
        distinct <= distinct + W_DISTINCT'(1);
        total    <= total + W_TOTAL'(1);
        dcount   <= {dcount[W_DCOUNT-2:0], 1'b0};
        dsum     <= dsum_prod;
      end
    end
  end

  assign stat.sq_over  = (sq > SQ_BITS'(rest));
  assign stat.div_done = div_done;
  assign stat.div_zero = rem_zero;
  assign stat.hit      = hit;

  assign smallest_prime  = below_two ? '0 : W_PRIME'(least);
  assign largest_prime   = below_two ? '0 : W_PRIME'(most);
  assign distinct_primes = below_two ? '0 : distinct;
  assign total_primes    = below_two ? '0 : total;
  assign divisor_count   = below_two ? '0 : dcount;
  assign divisor_sum     = below_two ? '0 : dsum;

endmodule

/* rtl/pfs_ctrl.sv */
// pfs_ctrl: sequencer for trial division, issues datapath commands.
// Depends on pfs_pkg for the command and status bundles.
module pfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pfs_pkg::pfs_stat_t stat,
  output pfs_pkg::pfs_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import pfs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TEST  = 3'd1;
  localparam logic [2:0] S_DIVGO = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.sq_over) begin
          cmd.tail   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.div_zero) begin
            // keep dividing by the same prime, regardless of the square bound
            cmd.take   = 1'b1;
            state_next = S_DIVGO;
          end else begin
            cmd.merge   = stat.hit;
            cmd.advance = 1'b1;
            state_next  = S_TEST;
          end
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

/* rtl/prime_factor_statistics_top.sv */
// prime_factor_statistics_top: factors one integer by trial division and
// reports its factor statistics. Depends on pfs_pkg, pfs_ctrl, pfs_datapath.
//
// Usage:
//   Drive value and raise start while busy is low; the transfer happens at
//   that clock edge and busy rises on the next cycle. busy stays high until
//   the result has been shown.
//   The six result ports are marked valid by done, high for exactly one cycle;
//   the receiver has no way to hold them, so it must capture them then.
//   Values below 2 give all-zero results.
// Operation:
//   Candidates are 2 and then odd numbers up to sqrt of the remainder; each
//   gets a bound check that starts the radix-4 divider, its DIV_STEPS steps
//   and its done strobe; each factor found costs another divider pass, with
//   no bound check. A large prime near 2^20 tries 512 candidates. One item
//   is in flight at a time; the next may start after done.
// Reset:
//   rst (synchronous, active high) returns the sequencer to idle and drops
//   busy and done; no state carries from one item to the next.
module prime_factor_statistics_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pfs_pkg::W_VALUE-1:0]    value,
  output logic                           busy,
  output logic                           done,
  output logic [pfs_pkg::W_PRIME-1:0]    smallest_prime,
  output logic [pfs_pkg::W_PRIME-1:0]    largest_prime,
  output logic [pfs_pkg::W_DISTINCT-1:0] distinct_primes,
  output logic [pfs_pkg::W_TOTAL-1:0]    total_primes,
  output logic [pfs_pkg::W_DCOUNT-1:0]   divisor_count,
  output logic [pfs_pkg::W_DSUM-1:0]     divisor_sum
);
  import pfs_pkg::*;

  pfs_cmd_t  cmd;
  pfs_stat_t stat;

  pfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pfs_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .value           (value),
    .cmd             (cmd),
    .stat            (stat),
    .smallest_prime  (smallest_prime),
    .largest_prime   (largest_prime),
    .distinct_primes (distinct_primes),
    .total_primes    (total_primes),
    .divisor_count   (divisor_count),
    .divisor_sum     (divisor_sum)
  );

endmodule

/* rtl/pfs_checker.sv */
// pfs_checker: port-level timing checks of the command handshake and result
// strobe, bound to prime_factor_statistics_top. No package dependency.
module pfs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

  // an accepted transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after transfer");

  // no result can appear the cycle right after a transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result too early after transfer");

  // a result is shown while busy and the block is free right after it
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block not released after result");

endmodule

bind prime_factor_statistics_top pfs_checker u_pfs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
